>>> rtl/fcvf_pkg.sv
// Package for the finger count vote filter: field widths, register indexes,
// configuration and queue entry types. Depends on nothing.
`default_nettype none
package fcvf_pkg;

  localparam int COORD_W     = 12;
  localparam int TIPS_W      = 4;
  localparam int CNT_W       = 8;
  localparam int BIN_CNT_W   = 9;
  localparam int COUNT_OUT_W = 3;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 12;

  localparam int VOTE_BINS_DEF = 7;
  localparam int Q_DEPTH       = 2;

  localparam logic [TIPS_W-1:0]    MAX_TIPS     = 4'd5;
  localparam int                   ASPECT_SHIFT = 2;  // aspect limit of 4
  localparam logic [BIN_CNT_W-1:0] BIN_MAX      = 9'd511;
  localparam logic [CNT_W-1:0]     CNT_MAX      = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_FRAMES = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_FRAMES  = 4'd3;

  localparam logic [COORD_W-1:0] MIN_HEIGHT_RST   = 12'd240;
  localparam logic [COORD_W-1:0] LEFT_MARGIN_RST  = 12'd20;
  localparam logic [CNT_W-1:0]   QUIET_FRAMES_RST = 8'd12;
  localparam logic [CNT_W-1:0]   VOTE_FRAMES_RST  = 8'd12;

  typedef struct packed {
    logic [COORD_W-1:0] min_height;
    logic [COORD_W-1:0] left_margin;
    logic [CNT_W-1:0]   quiet_frames;
    logic [CNT_W-1:0]   vote_frames;
  } cfg_t;

  // one classified frame on its way from front to back
  typedef struct packed {
    logic              shape_ok;  // height and hand test both passed
    logic [TIPS_W-1:0] tips;
  } qent_t;

endpackage
`default_nettype wire

>>> rtl/fcvf_cfg.sv
// Configuration register file of the finger count vote filter.
// Depends on fcvf_pkg.
`default_nettype none
module fcvf_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fcvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcvf_pkg::CFG_DATA_W-1:0] cfg_data,
  output fcvf_pkg::cfg_t                      cfg
);
  import fcvf_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_HEIGHT:   cfg_nxt.min_height   = cfg_data;
        CFG_LEFT_MARGIN:  cfg_nxt.left_margin  = cfg_data;
        CFG_QUIET_FRAMES: cfg_nxt.quiet_frames = cfg_data[CNT_W-1:0];
        CFG_VOTE_FRAMES:  cfg_nxt.vote_frames  = cfg_data[CNT_W-1:0];
        default:          cfg_nxt = cfg_r;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_height   <= MIN_HEIGHT_RST;
      cfg_r.left_margin  <= LEFT_MARGIN_RST;
      cfg_r.quiet_frames <= QUIET_FRAMES_RST;
      cfg_r.vote_frames  <= VOTE_FRAMES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fcvf_front.sv
// Front end of the finger count vote filter: takes input beats and runs the
// height and hand shape tests. Depends on fcvf_pkg.
`default_nettype none
module fcvf_front (
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fcvf_pkg::COORD_W-1:0] in_box_x,
  input  wire logic [fcvf_pkg::COORD_W-1:0] in_box_width,
  input  wire logic [fcvf_pkg::COORD_W-1:0] in_box_height,
  input  wire logic [fcvf_pkg::TIPS_W-1:0]  in_tip_count,
  input  wire fcvf_pkg::cfg_t               cfg,
  output logic                              push,
  output fcvf_pkg::qent_t                   push_ent,
  input  wire logic                         q_ready
);
  import fcvf_pkg::*;

  localparam int WIDE_W = COORD_W + ASPECT_SHIFT;

  logic [WIDE_W-1:0] w4, h4, w_ext, h_ext;
  logic              shape_ok;

  assign w_ext = WIDE_W'(in_box_width);
  assign h_ext = WIDE_W'(in_box_height);
  assign w4    = w_ext << ASPECT_SHIFT;
  assign h4    = h_ext << ASPECT_SHIFT;

  // shape tests; exact cross-multiplied aspect test, no division
  always_comb begin
    shape_ok = 1'b1;
    if (in_tip_count > MAX_TIPS)                      shape_ok = 1'b0;
    if (in_box_height == '0 || in_box_width == '0)    shape_ok = 1'b0;
    if (h_ext > w4 || w_ext > h4)                     shape_ok = 1'b0;
    if (in_box_x < cfg.left_margin)                   shape_ok = 1'b0;
    if (!(in_box_height > cfg.min_height))            shape_ok = 1'b0;
  end

  assign in_ready          = q_ready;
  assign push              = in_valid && q_ready;
  assign push_ent.shape_ok = shape_ok;
  assign push_ent.tips     = in_tip_count;

endmodule
`default_nettype wire

>>> rtl/fcvf_queue.sv
// Short queue of classified frames between front and back end.
// Depends on fcvf_pkg.
`default_nettype none
module fcvf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fcvf_pkg::qent_t push_ent,
  output logic                 q_ready,
  output logic                 q_valid,
  output fcvf_pkg::qent_t      q_ent,
  input  wire logic            pop
);
  import fcvf_pkg::*;

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(Q_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(Q_DEPTH - 1);

  qent_t         mem_r [Q_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign q_ready = (count_r != FULL);
  assign q_valid = (count_r != '0);
  assign q_ent   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fcvf_back.sv
// Back end of the finger count vote filter: gap and vote counters, histogram,
// running winner and the output register. Depends on fcvf_pkg.
`default_nettype none
module fcvf_back #(
  parameter int VOTE_BINS = fcvf_pkg::VOTE_BINS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fcvf_pkg::cfg_t                   cfg,
  input  wire logic                             q_valid,
  input  wire fcvf_pkg::qent_t                  q_ent,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_frame_accepted,
  output logic                                  out_decision_ready,
  output logic [fcvf_pkg::COUNT_OUT_W-1:0]      out_finger_count
);
  import fcvf_pkg::*;

  localparam int BIN_W = (VOTE_BINS > 1) ? $clog2(VOTE_BINS) : 1;
  localparam logic [TIPS_W:0] BINS_L = (TIPS_W + 1)'(VOTE_BINS);

  logic [BIN_CNT_W-1:0]   hist_r [VOTE_BINS];
  logic [BIN_CNT_W-1:0]   hist_nxt [VOTE_BINS];
  logic [CNT_W-1:0]       gap_r, gap_nxt;
  logic [CNT_W-1:0]       vote_idx_r, vote_idx_nxt;
  logic [BIN_W-1:0]       best_bin_r, best_bin_nxt;
  logic [BIN_CNT_W-1:0]   best_val_r, best_val_nxt;
  logic [COUNT_OUT_W-1:0] decided_r, decided_nxt;

  logic                   out_valid_r;
  logic                   acc_r, dec_r;

  logic                   accept_c, decide_c, tally_c, inc_c;
  logic [BIN_W-1:0]       bin_idx;
  logic [BIN_CNT_W-1:0]   bin_cnt, new_cnt;

  assign pop = q_valid && (!out_valid_r || out_ready);

  assign accept_c = q_ent.shape_ok && (gap_r > cfg.quiet_frames);
  assign decide_c = accept_c && (vote_idx_r > cfg.vote_frames);
  assign tally_c  = accept_c && ({1'b0, q_ent.tips} < BINS_L);
  assign bin_idx  = q_ent.tips[BIN_W-1:0];
  assign bin_cnt  = hist_r[bin_idx];
  assign inc_c    = tally_c && (bin_cnt != BIN_MAX);
  assign new_cnt  = bin_cnt + 1'b1;

  // The histogram only grows by one bin per frame, so the lowest-index
  // maximum over bins 1 and up can be tracked as it changes.
  always_comb begin
    hist_nxt     = hist_r;
    gap_nxt      = gap_r;
    vote_idx_nxt = vote_idx_r;
    best_bin_nxt = best_bin_r;
    best_val_nxt = best_val_r;
    decided_nxt  = decided_r;

    if (inc_c) begin
      hist_nxt[bin_idx] = new_cnt;
      if (bin_idx != '0) begin
        if (new_cnt > best_val_r ||
            (new_cnt == best_val_r && bin_idx < best_bin_r)) begin
          best_bin_nxt = bin_idx;
          best_val_nxt = new_cnt;
        end
      end
    end

    if (decide_c) begin
      // keep the old count when no vote landed in bins 1 and up
      if (best_val_nxt != '0) begin
        decided_nxt = COUNT_OUT_W'(best_bin_nxt);
      end
      for (int b = 0; b < VOTE_BINS; b++) begin
        hist_nxt[b] = '0;
      end
      best_bin_nxt = '0;
      best_val_nxt = '0;
      gap_nxt      = '0;
      vote_idx_nxt = '0;
    end else if (accept_c) begin
      if (vote_idx_r != CNT_MAX) begin
        vote_idx_nxt = vote_idx_r + 1'b1;
      end
    end else if (gap_r != CNT_MAX) begin
      gap_nxt = gap_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < VOTE_BINS; b++) begin
        hist_r[b] <= '0;
      end
      gap_r       <= '0;
      vote_idx_r  <= '0;
      best_bin_r  <= '0;
      best_val_r  <= '0;
      decided_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        hist_r     <= hist_nxt;
        gap_r      <= gap_nxt;
        vote_idx_r <= vote_idx_nxt;
        best_bin_r <= best_bin_nxt;
        best_val_r <= best_val_nxt;
        decided_r  <= decided_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_r <= accept_c;
      dec_r <= decide_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_accepted = acc_r;
  assign out_decision_ready = dec_r;
  assign out_finger_count   = decided_r;

`ifndef SYNTH
  a_dec_implies_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!dec_r || acc_r))
    else $error("decision reported on a frame that was not a vote");

  a_decide_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && decide_c) |=> (vote_idx_r == '0 && gap_r == '0 && best_val_r == '0))
    else $error("counters not cleared after a decision");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> ($stable(gap_r) && $stable(vote_idx_r) && $stable(decided_r)))
    else $error("vote state moved without a frame");

  a_accept_keeps_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && accept_c && !decide_c) |=> $stable(gap_r))
    else $error("gap counter changed on an accepted frame");
`endif

endmodule
`default_nettype wire

>>> rtl/finger_count_vote_filter_top.sv
// Top level of the finger count vote filter.
// Depends on fcvf_pkg, fcvf_cfg, fcvf_front, fcvf_queue and fcvf_back.
`default_nettype none
// The block takes one beat per video frame (hand bounding box and fingertip
// count) and returns exactly one result beat per frame, in order. A frame is
// taken as a vote when its box is taller than min_height, more than
// quiet_frames rejected frames have passed since the last decision, and the
// box passes the hand test (at most five tips, nonzero sides, neither side
// over four times the other, left edge at or past left_margin). Votes tally
// into a histogram; the vote that arrives once the round index exceeds
// vote_frames decides the most frequent count from 1 upward (ties to the
// lowest), then the round restarts. One beat is accepted every clock cycle
// while the queue has room; each result passes through the two-entry queue
// behind the classifying front end, then the output register of the vote back
// end, whose counter and histogram update is registered with the result beat.
// Either side may stall without stopping the other until the queue fills.
// Write configuration only while no frame is in flight; cfg_ready is always
// high and writes to unknown indexes are dropped.
module finger_count_vote_filter_top #(
  parameter int VOTE_BINS = fcvf_pkg::VOTE_BINS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [fcvf_pkg::COORD_W-1:0]      in_box_x,
  input  wire logic [fcvf_pkg::COORD_W-1:0]      in_box_width,
  input  wire logic [fcvf_pkg::COORD_W-1:0]      in_box_height,
  input  wire logic [fcvf_pkg::TIPS_W-1:0]       in_tip_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_frame_accepted,
  output logic                                  out_decision_ready,
  output logic [fcvf_pkg::COUNT_OUT_W-1:0]      out_finger_count,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fcvf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcvf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fcvf_pkg::*;

  cfg_t  cfg;
  logic  push, q_ready, q_valid, pop;
  qent_t push_ent, q_ent;

  // hold the register file
  fcvf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // classify each frame as it arrives
  fcvf_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_box_x      (in_box_x),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_tip_count  (in_tip_count),
    .cfg           (cfg),
    .push          (push),
    .push_ent      (push_ent),
    .q_ready       (q_ready)
  );

  // decouple front and back
  fcvf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_ent    (q_ent),
    .pop      (pop)
  );

  // advance the vote state and register the result beat
  fcvf_back #(
    .VOTE_BINS (VOTE_BINS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_ent              (q_ent),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_accepted (out_frame_accepted),
    .out_decision_ready (out_decision_ready),
    .out_finger_count   (out_finger_count)
  );

endmodule
`default_nettype wire

>>> verif/finger_count_vote_filter_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for finger_count_vote_filter_top: directed and random frame
// beats against a cycle-free predictor. Depends on fcvf_pkg and the RTL only.
module finger_count_vote_filter_top_tb;
  import fcvf_pkg::*;

  // Predictor constants, kept apart from the RTL on purpose.
  localparam int HAND_TIP_MAX = 5;
  localparam int ASPECT       = 4;
  localparam int TALLY_MAX    = 511;
  localparam int COUNTER_TOP  = 255;
  localparam int NUM_BINS     = VOTE_BINS_DEF;
  localparam int COORD_TOP    = (1 << COORD_W) - 1;

  // Indexes with no register behind them; writes here must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX    = 4'd15;

  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [TIPS_W-1:0]  tips;
  } frame_t;

  typedef struct packed {
    logic                   accepted;
    logic                   decided;
    logic [COUNT_OUT_W-1:0] count;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [COORD_W-1:0]     in_box_x = '0;
  logic [COORD_W-1:0]     in_box_width = '0;
  logic [COORD_W-1:0]     in_box_height = '0;
  logic [TIPS_W-1:0]      in_tip_count = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_frame_accepted;
  logic                   out_decision_ready;
  logic [COUNT_OUT_W-1:0] out_finger_count;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  finger_count_vote_filter_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_box_x           (in_box_x),
    .in_box_width       (in_box_width),
    .in_box_height      (in_box_height),
    .in_tip_count       (in_tip_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_accepted (out_frame_accepted),
    .out_decision_ready (out_decision_ready),
    .out_finger_count   (out_finger_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the filter: register copy plus counters and histogram.
  cfg_t filt_cfg;
  int   gap_run;
  int   round_pos;
  int   tally [NUM_BINS];
  logic [COUNT_OUT_W-1:0] held_count;

  verdict_t verdicts_due [$];

  int          errors = 0;
  int unsigned cycles = 0;
  bit          idle_draws_on = 1'b1;  // clear for stretches with no idling
  int          rx_hold = 0;           // long receiver hold-off, in cycles
  int          rx_wait = 0;           // per-beat receiver stall

  function automatic int draw_gap();
    return idle_draws_on ? $urandom_range(17, 0) : 0;
  endfunction

  function automatic frame_t box(int x, int w, int h, int tips);
    frame_t f;
    f.x = x[COORD_W-1:0];
    f.w = w[COORD_W-1:0];
    f.h = h[COORD_W-1:0];
    f.tips = tips[TIPS_W-1:0];
    return f;
  endfunction

  // Well-formed hand for the current settings: tall enough, in ratio, in margin.
  function automatic frame_t make_hand(int tips);
    int lo;
    int hi;
    int h;
    lo = int'(filt_cfg.min_height) + 1;
    if (lo > COORD_TOP) lo = COORD_TOP;
    hi = (lo + 500 > COORD_TOP) ? COORD_TOP : lo + 500;
    h = $urandom_range(hi, lo);
    lo = (h + ASPECT - 1) / ASPECT;
    hi = (ASPECT * h > COORD_TOP) ? COORD_TOP : ASPECT * h;
    return box($urandom_range(COORD_TOP, int'(filt_cfg.left_margin)),
               $urandom_range(hi, lo), h, tips);
  endfunction

  function automatic frame_t make_noise();
    return box($urandom, $urandom, $urandom, $urandom);
  endfunction

  // Predict the result of one accepted frame and advance the shadow state.
  function automatic verdict_t judge_frame(frame_t f);
    verdict_t v;
    logic     hand_ok;
    int       best;
    v = '0;
    hand_ok = (int'(f.tips) <= HAND_TIP_MAX) && (f.w != 0) && (f.h != 0)
           && (int'(f.h) <= ASPECT * int'(f.w)) && (int'(f.w) <= ASPECT * int'(f.h))
           && (f.x >= filt_cfg.left_margin);
    if (f.h > filt_cfg.min_height && gap_run > int'(filt_cfg.quiet_frames) && hand_ok) begin
      v.accepted = 1'b1;
      if (int'(f.tips) < NUM_BINS && tally[f.tips] < TALLY_MAX) tally[f.tips]++;
      if (round_pos > int'(filt_cfg.vote_frames)) begin
        // Close the round: pick the largest tally from bin 1 up, lowest on a tie.
        gap_run = 0;
        round_pos = 0;
        best = 0;
        for (int b = 1; b < NUM_BINS; b++) begin
          if (tally[b] > best) begin
            best = tally[b];
            held_count = COUNT_OUT_W'(b);
          end
        end
        foreach (tally[b]) tally[b] = 0;
        v.decided = 1'b1;
      end else if (round_pos < COUNTER_TOP) begin
        round_pos++;
      end
    end else if (gap_run < COUNTER_TOP) begin
      gap_run++;
    end
    v.count = held_count;
    return v;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 30)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  // Offer one frame beat after a random gap; hold it until accepted, then
  // queue its predicted result.
  task automatic send_frame(frame_t f);
    int       idle;
    verdict_t due;
    idle = draw_gap();
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_box_x      <= f.x;
    in_box_width  <= f.w;
    in_box_height <= f.h;
    in_tip_count  <= f.tips;
    do @(posedge clk); while (!in_ready);
    due = judge_frame(f);
    verdicts_due = {verdicts_due, due};
  endtask

  // Drop valid and drain until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_HEIGHT:   filt_cfg.min_height   = data;
      CFG_LEFT_MARGIN:  filt_cfg.left_margin  = data;
      CFG_QUIET_FRAMES: filt_cfg.quiet_frames = data[CNT_W-1:0];
      CFG_VOTE_FRAMES:  filt_cfg.vote_frames  = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int mh, int lm, int qf, int vf);
    settle();
    write_reg(CFG_MIN_HEIGHT, mh[CFG_DATA_W-1:0]);
    write_reg(CFG_LEFT_MARGIN, lm[CFG_DATA_W-1:0]);
    write_reg(CFG_QUIET_FRAMES, qf[CFG_DATA_W-1:0]);
    write_reg(CFG_VOTE_FRAMES, vf[CFG_DATA_W-1:0]);
  endtask

  // Rounds of quiet gap then votes; the gap is sometimes too short on purpose.
  task automatic run_rounds(int n_items);
    int sent;
    int rejects;
    int votes;
    sent = 0;
    while (sent < n_items) begin
      rejects = $urandom_range(int'(filt_cfg.quiet_frames) + 3, 0);
      votes = int'(filt_cfg.vote_frames) + 2 + $urandom_range(2, 0);
      repeat (rejects) begin
        send_frame(make_noise());
        sent++;
      end
      repeat (votes) begin
        if ($urandom_range(9, 0) == 0) send_frame(make_noise());
        else send_frame(make_hand($urandom_range(HAND_TIP_MAX, 0)));
        sent++;
      end
    end
  endtask

  // Reset values: 13 short boxes open the gap, 14 votes close one round.
  task automatic test_reset_config();
    repeat (13) send_frame(box(100, 100, 0, 3));
    repeat (14) send_frame(box(100, 150, 300, 3));
  endtask

  task automatic test_hand_shapes();
    apply_setting(100, 20, 0, 1);
    send_frame(box(0, 0, 0, 0));
    send_frame(box(COORD_TOP, COORD_TOP, COORD_TOP, 15));
    send_frame(box(COORD_TOP, COORD_TOP, COORD_TOP, 5));
    send_frame(box(20, 100, 400, 3));      // height exactly four widths
    send_frame(box(19, 100, 400, 3));      // one pixel inside the margin
    send_frame(box(20, 100, 401, 3));      // too tall for its width
    send_frame(box(20, 404, 101, 2));      // three-way tie, lowest count wins
    send_frame(box(20, 405, 101, 2));      // too wide for its height
    send_frame(box(20, 0, 200, 1));
    send_frame(box(20, 200, 0, 1));
    send_frame(box(20, 100, 100, 1));      // height equal to the threshold
    send_frame(box(20, 50, 101, 6));       // six tips is not a hand
    send_frame(box(COORD_TOP, 1, 101, 1));
    // A round of zero-tip votes decides but keeps the held count.
    repeat (3) send_frame(box(300, 100, 200, 0));
    send_frame(box(40, 120, 480, 4));
    send_frame(box(40, 120, 480, 4));
    send_frame(box(40, 120, 480, 1));
  endtask

  task automatic test_register_extremes();
    apply_setting(COORD_TOP, COORD_TOP, 0, 0);
    repeat (3) send_frame(box(COORD_TOP, COORD_TOP, COORD_TOP, 2));
    apply_setting(0, COORD_TOP, 0, 0);
    send_frame(box(COORD_TOP, 1, 1, 2));
    send_frame(box(COORD_TOP - 1, 1, 1, 2));
    send_frame(box(COORD_TOP, 1, 1, 2));
    send_frame(box(COORD_TOP, 4, 1, 1));
    apply_setting(0, 0, 0, 0);
    // Writes to unused indexes must leave every register as it was.
    write_reg(CFG_FIRST_UNUSED, '1);
    write_reg(CFG_SPARE_IDX, '1);
    send_frame(box(0, 1, 1, 0));
    send_frame(box(0, 1, 1, 1));
    send_frame(box(0, 2, 1, 5));
    send_frame(box(0, 1, 1, 5));
  endtask

  // Hold the receiver off while beats keep coming so the input stalls.
  task automatic test_output_backpressure();
    apply_setting(100, 0, 1, 3);
    idle_draws_on = 1'b0;
    @(posedge clk);
    rx_hold = 80;
    run_rounds(40);
    idle_draws_on = 1'b1;
  endtask

  // Saturate the gap and the round index; a wrapped index would miss the
  // decision on the last vote.
  task automatic test_counter_saturation();
    apply_setting(100, 0, 254, 'hFFF);
    idle_draws_on = 1'b0;
    repeat (256) send_frame(box($urandom, $urandom, 0, $urandom));
    repeat (256) send_frame(make_hand($urandom_range(HAND_TIP_MAX, 0)));
    settle();
    write_reg(CFG_VOTE_FRAMES, '0);
    send_frame(make_hand(0));
    // With the quiet gap at its top no frame can ever vote.
    settle();
    write_reg(CFG_QUIET_FRAMES, 'hFFF);
    repeat (6) send_frame(make_hand(3));
    idle_draws_on = 1'b1;
  endtask

  task automatic test_random_rounds();
    for (int phase = 0; phase < 6; phase++) begin
      apply_setting($urandom_range(600, 0), $urandom_range(200, 0),
                    $urandom_range(5, 0), $urandom_range(6, 0));
      idle_draws_on = (phase % 3 != 2);
      run_rounds(10);
    end
    idle_draws_on = 1'b1;
  endtask

  // Receiver: long hold-off first, then the per-beat stall, else ready.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch("result beat with nothing expected", 1, 0);
      end else begin
        want = verdicts_due.pop_front();
        if (out_frame_accepted !== want.accepted)
          flag_mismatch("frame_accepted", int'(out_frame_accepted), int'(want.accepted));
        if (out_decision_ready !== want.decided)
          flag_mismatch("decision_ready", int'(out_decision_ready), int'(want.decided));
        if (out_finger_count !== want.count)
          flag_mismatch("finger_count", int'(out_finger_count), int'(want.count));
      end
      rx_wait = draw_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    filt_cfg.min_height   = MIN_HEIGHT_RST;
    filt_cfg.left_margin  = LEFT_MARGIN_RST;
    filt_cfg.quiet_frames = QUIET_FRAMES_RST;
    filt_cfg.vote_frames  = VOTE_FRAMES_RST;
    gap_run = 0;
    round_pos = 0;
    foreach (tally[b]) tally[b] = 0;
    held_count = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_hand_shapes();
    test_register_extremes();
    test_output_backpressure();
    test_counter_saturation();
    test_random_rounds();

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fcvf_pkg.sv
rtl/fcvf_cfg.sv
rtl/fcvf_front.sv
rtl/fcvf_queue.sv
rtl/fcvf_back.sv
rtl/finger_count_vote_filter_top.sv
verif/finger_count_vote_filter_top_tb.sv
